// ----- design/bgc_pkg.sv -----
package bgc_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_SHORT_MIN   = 2'd0;
    localparam logic [1:0] CFG_LONG_MIN    = 2'd1;
    localparam logic [1:0] CFG_DBL_WINDOW  = 2'd2;
    localparam logic [1:0] CFG_CONFIRM_DLY = 2'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_SHORT_MIN   = 16'd30;
    localparam logic [15:0] RST_LONG_MIN    = 16'd1000;
    localparam logic [15:0] RST_DBL_WINDOW  = 16'd300;
    localparam logic [7:0]  RST_CONFIRM_DLY = 8'd20;

    // Gesture codes
    localparam logic [1:0] G_SHORT  = 2'd0;
    localparam logic [1:0] G_LONG   = 2'd1;
    localparam logic [1:0] G_DOUBLE = 2'd2;

    // Input item kinds
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_EDGE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WINDOW  = 2'd1,
        PH_CONFIRM = 2'd2
    } t_phase;

    // One classifier result toward the output buffer
    typedef struct packed {
        logic       valid;
        logic [1:0] gesture;
    } t_result;

endpackage

// ----- design/bgc_core.sv -----
module bgc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic               i_cmd,
    input  logic               i_pin_level,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output bgc_pkg::t_result   o_result
);
    import bgc_pkg::*;

    logic [15:0] r_short_min;
    logic [15:0] r_long_min;
    logic [15:0] r_dbl_window;
    logic [7:0]  r_confirm_dly;

    t_phase      r_phase, n_phase;
    logic [15:0] r_held, n_held;
    logic [15:0] r_window, n_window;
    logic [7:0]  r_confirm, n_confirm;
    logic        r_skip, n_skip;
    t_result     r_result, n_result;

    logic        is_edge;
    logic        is_low;
    logic [15:0] win_inc;
    logic [7:0]  conf_inc;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_min   <= RST_SHORT_MIN;
            r_long_min    <= RST_LONG_MIN;
            r_dbl_window  <= RST_DBL_WINDOW;
            r_confirm_dly <= RST_CONFIRM_DLY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SHORT_MIN:   r_short_min   <= i_cfg_data;
                CFG_LONG_MIN:    r_long_min    <= i_cfg_data;
                CFG_DBL_WINDOW:  r_dbl_window  <= i_cfg_data;
                CFG_CONFIRM_DLY: r_confirm_dly <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign is_edge  = (i_cmd == CMD_EDGE);
    assign is_low   = !i_pin_level;
    assign win_inc  = (r_window == 16'hFFFF) ? r_window : r_window + 16'd1;
    assign conf_inc = (r_confirm == 8'hFF) ? r_confirm : r_confirm + 8'd1;

    // Next state and result for one item
    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_window  = r_window;
        n_confirm = r_confirm;
        n_skip    = r_skip;
        n_result  = '{valid: 1'b0, gesture: G_SHORT};
        case (r_phase)
            PH_WINDOW: begin
                if (!is_edge) begin
                    n_window = win_inc;
                    if (win_inc >= r_dbl_window) begin
                        n_result = '{valid: 1'b1, gesture: G_SHORT};
                        n_phase  = PH_IDLE;
                        n_held   = '0;
                    end
                end else if (is_low) begin
                    if (r_confirm_dly == 8'd0) begin
                        n_skip   = 1'b1;
                        n_result = '{valid: 1'b1, gesture: G_DOUBLE};
                        n_phase  = PH_IDLE;
                        n_held   = '0;
                    end else begin
                        n_phase   = PH_CONFIRM;
                        n_confirm = '0;
                    end
                end
            end
            PH_CONFIRM: begin
                // edges are dropped during the confirm delay
                if (!is_edge) begin
                    n_window  = win_inc;
                    n_confirm = conf_inc;
                    if (conf_inc >= r_confirm_dly) begin
                        if (is_low) begin
                            n_skip   = 1'b1;
                            n_result = '{valid: 1'b1, gesture: G_DOUBLE};
                            n_phase  = PH_IDLE;
                            n_held   = '0;
                        end else if (win_inc >= r_dbl_window) begin
                            n_result = '{valid: 1'b1, gesture: G_SHORT};
                            n_phase  = PH_IDLE;
                            n_held   = '0;
                        end else begin
                            n_phase = PH_WINDOW;
                        end
                    end
                end
            end
            default: begin
                // idle, and the unused code behaves the same
                n_phase = PH_IDLE;
                if (!is_edge) begin
                    if (r_held != 16'hFFFF) n_held = r_held + 16'd1;
                end else if (is_low) begin
                    n_held = '0;
                end else if (r_skip) begin
                    n_skip = 1'b0;
                    n_held = '0;
                end else if (r_held > r_short_min) begin
                    n_held = '0;
                    if (r_held > r_long_min) begin
                        n_result = '{valid: 1'b1, gesture: G_LONG};
                    end else begin
                        n_phase  = PH_WINDOW;
                        n_window = '0;
                    end
                end
            end
        endcase
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_held    <= '0;
            r_window  <= '0;
            r_confirm <= '0;
            r_skip    <= 1'b0;
            r_result  <= '{valid: 1'b0, gesture: G_SHORT};
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_window  <= n_window;
            r_confirm <= n_confirm;
            r_skip    <= n_skip;
            r_result  <= n_result;
        end else begin
            r_result.valid <= 1'b0;
        end
    end

    assign o_result = r_result;

endmodule

// ----- design/button_gesture_classifier.sv -----
// A gesture passes from the input transfer that causes it into the result register in the
// core, and from there into the output buffer, which drives the output.
// Throughput: one item per cycle while input ready is high; one pass of logic per item.
// A two-entry output buffer lets items keep flowing while a result waits; input
// ready drops while both entries are held, or while one is held and a result is entering.
// Reset (synchronous, active low) returns the classifier to idle, clears counters
// and the output buffer, and loads the default timing registers.
module button_gesture_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic        i_pin_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_gesture,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import bgc_pkg::*;

    t_result    core_result;
    logic       take;
    logic       pop;
    logic       push;
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_buf [2];

    assign take        = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    bgc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_cmd       (i_cmd),
        .i_pin_level (i_pin_level),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (core_result)
    );

    // Output buffer: room for the registered result plus one waiting transfer
    assign push        = core_result.valid;
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_gesture   = r_buf[r_rd];
    assign o_in_ready  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !core_result.valid);

    always_ff @(posedge i_clk) begin
        if (push) r_buf[r_wr] <= core_result.gesture;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

// ----- design/bgc_checker.sv -----
module bgc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_gesture
);
    import bgc_pkg::*;

    // A waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_gesture))
        else $error("output changed while stalled");

    // Only defined gesture codes leave the block
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_gesture == G_SHORT || o_gesture == G_LONG ||
                         o_gesture == G_DOUBLE))
        else $error("undefined gesture code");

    // Input back-pressure only while results are waiting
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // Reset empties the output buffer
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_gesture   (o_gesture)
);

// ----- verif/tb_button_gesture_classifier.sv -----
module tb_button_gesture_classifier;
    import bgc_pkg::*;

    typedef struct packed {
        logic cmd;
        logic pin;
    } t_item;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_cmd = CMD_TICK;
    logic        in_pin = 1'b1;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_SHORT_MIN;
    logic [15:0] cfg_data = 16'd0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_gesture;
    logic        o_cfg_ready;

    button_gesture_classifier DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (in_cmd),
        .i_pin_level (in_pin),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_gesture   (o_gesture),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Items waiting to be sent and gestures waiting to come out
    t_item      pending[$];
    logic [1:0] gestures_due[$];

    int  n_gen = 0;
    int  n_in = 0;
    int  n_err = 0;
    int  n_settings = 0;
    int  n_kind[3] = '{0, 0, 0};
    logic quiet = 1'b0;

    // Timing registers as the classifier should see them
    logic [15:0] m_short   = RST_SHORT_MIN;
    logic [15:0] m_long    = RST_LONG_MIN;
    logic [15:0] m_window  = RST_DBL_WINDOW;
    logic [7:0]  m_confirm = RST_CONFIRM_DLY;

    // Classifier state
    t_phase      ph = PH_IDLE;
    logic [15:0] held = 16'd0;
    logic [15:0] win_cnt = 16'd0;
    logic [7:0]  conf_cnt = 8'd0;
    logic        skip_rel = 1'b0;

    // A gesture ends the current press sequence
    task automatic push_gesture(input logic [1:0] g);
        gestures_due.push_back(g);
        ph = PH_IDLE;
        held = 16'd0;
    endtask

    // Advance the classifier by one accepted item
    task automatic classify(input logic cmd, input logic pin);
        logic is_edge;
        logic low;
        is_edge = (cmd == CMD_EDGE);
        low = (pin == 1'b0);
        case (ph)
            PH_WINDOW: begin
                if (!is_edge) begin
                    if (win_cnt != 16'hFFFF) win_cnt = win_cnt + 16'd1;
                    if (win_cnt >= m_window) push_gesture(G_SHORT);
                end else if (low) begin
                    if (m_confirm == 8'd0) begin
                        skip_rel = 1'b1;
                        push_gesture(G_DOUBLE);
                    end else begin
                        ph = PH_CONFIRM;
                        conf_cnt = 8'd0;
                    end
                end
            end
            PH_CONFIRM: begin
                // edges are dropped during the confirm delay
                if (!is_edge) begin
                    if (win_cnt != 16'hFFFF) win_cnt = win_cnt + 16'd1;
                    if (conf_cnt != 8'hFF) conf_cnt = conf_cnt + 8'd1;
                    if (conf_cnt >= m_confirm) begin
                        if (low) begin
                            skip_rel = 1'b1;
                            push_gesture(G_DOUBLE);
                        end else if (win_cnt >= m_window) begin
                            push_gesture(G_SHORT);
                        end else begin
                            ph = PH_WINDOW;
                        end
                    end
                end
            end
            default: begin
                ph = PH_IDLE;
                if (!is_edge) begin
                    if (held != 16'hFFFF) held = held + 16'd1;
                end else if (low) begin
                    held = 16'd0;
                end else if (skip_rel) begin
                    skip_rel = 1'b0;
                    held = 16'd0;
                end else if (held > m_short) begin
                    if (held > m_long) begin
                        push_gesture(G_LONG);
                    end else begin
                        ph = PH_WINDOW;
                        win_cnt = 16'd0;
                        held = 16'd0;
                    end
                end
            end
        endcase
    endtask

    // Driver: one item per transfer, random gaps outside the quiet stretch
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                classify(in_cmd, in_pin);
                n_in++;
            end
            if (!in_valid || o_in_ready) begin
                if (pending.size() != 0 && (quiet || $urandom_range(99) >= 8)) begin
                    in_cmd <= pending[0].cmd;
                    in_pin <= pending[0].pin;
                    void'(pending.pop_front());
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            quiet <= (n_in >= 600 && n_in < 900);
        end
    end

    // Monitor: random back-pressure, check each gesture transfer
    always @(posedge i_clk) begin
        out_ready <= quiet || ($urandom_range(99) >= 8);
        if (rst_n && o_out_valid && out_ready) begin
            if (gestures_due.size() == 0) begin
                $error("gesture: expected none, actual %0d", o_gesture);
                n_err++;
            end else begin
                if (o_gesture !== gestures_due[0]) begin
                    $error("gesture: expected %0d, actual %0d", gestures_due[0], o_gesture);
                    n_err++;
                end
                if (gestures_due[0] < 2'd3) n_kind[gestures_due[0]]++;
                void'(gestures_due.pop_front());
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SHORT_MIN:   m_short = val;
            CFG_LONG_MIN:    m_long = val;
            CFG_DBL_WINDOW:  m_window = val;
            CFG_CONFIRM_DLY: m_confirm = val[7:0];
            default: ;
        endcase
    endtask

    // Hold the sender until everything sent has been answered
    task automatic settle();
        do @(negedge i_clk); while (pending.size() != 0 || in_valid || gestures_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [15:0] s, input logic [15:0] l,
                              input logic [15:0] w, input logic [7:0] c);
        settle();
        write_reg(CFG_SHORT_MIN, s);
        write_reg(CFG_LONG_MIN, l);
        write_reg(CFG_DBL_WINDOW, w);
        write_reg(CFG_CONFIRM_DLY, {8'd0, c});
        n_settings++;
        @(negedge i_clk);
    endtask

    task automatic add_item(input logic cmd, input logic pin);
        pending.push_back('{cmd: cmd, pin: pin});
        n_gen++;
    endtask

    task automatic add_ticks(input int unsigned n, input logic pin);
        repeat (n) add_item(CMD_TICK, pin);
    endtask

    function automatic int unsigned capped(input int unsigned v);
        return (v > 300) ? 300 : v;
    endfunction

    // One press sequence: mostly well formed, some noise
    task automatic add_gesture();
        int unsigned sel;
        int unsigned lo;
        int unsigned hi;
        sel = $urandom_range(99);
        if (sel < 20) begin
            repeat ($urandom_range(1, 6)) add_item(1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
            case ($urandom_range(2))
                0: begin lo = 0; hi = m_short; end
                1: begin lo = m_short + 1; hi = (m_long > m_short) ? m_long : m_short + 1; end
                default: begin lo = m_long + 1; hi = m_long + 8; end
            endcase
            add_item(CMD_EDGE, 1'b0);
            add_ticks($urandom_range(capped(lo), capped(hi)), 1'b0);
            add_item(CMD_EDGE, 1'b1);
            if (sel < 65) begin
                // second press, sometimes bouncing, level checked after the delay
                add_ticks($urandom_range(0, capped(m_window + 1)), 1'b1);
                add_item(CMD_EDGE, 1'b0);
                if ($urandom_range(3) == 0) add_item(CMD_EDGE, 1'($urandom_range(1)));
                repeat ($urandom_range(0, capped(m_confirm + 2)))
                    add_item(CMD_TICK, ($urandom_range(99) < 75) ? 1'b0 : 1'b1);
                add_item(CMD_EDGE, 1'b1);
            end
            add_ticks($urandom_range(0, capped(m_window + 3)), 1'b1);
        end
    endtask

    initial begin : stimulus
        int rand_start;
        logic [15:0] s;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // reset timing values
        repeat (2) add_gesture();

        // directed sequences
        set_timing(16'd1, 16'd3, 16'd3, 8'd1);
        add_item(CMD_EDGE, 1'b0);           // zero-length press
        add_item(CMD_EDGE, 1'b1);
        add_ticks(2, 1'b1);                 // release with no press edge opens window
        add_item(CMD_EDGE, 1'b1);
        add_item(CMD_EDGE, 1'b1);           // release in window is ignored
        add_ticks(3, 1'b1);                 // window runs out: short
        add_item(CMD_EDGE, 1'b0);           // long press
        add_ticks(4, 1'b0);
        add_item(CMD_EDGE, 1'b1);
        add_item(CMD_EDGE, 1'b0);           // press into window
        add_ticks(2, 1'b0);
        add_item(CMD_EDGE, 1'b1);
        add_item(CMD_EDGE, 1'b0);           // second press
        add_item(CMD_EDGE, 1'b1);           // dropped during confirm
        add_item(CMD_TICK, 1'b1);           // pin high at check: back to window
        add_item(CMD_EDGE, 1'b0);
        add_item(CMD_TICK, 1'b0);           // pin low at check: double
        add_item(CMD_EDGE, 1'b0);           // press does not clear the skip
        add_item(CMD_EDGE, 1'b1);           // skipped release

        // random timing settings with small values
        rand_start = n_gen;
        while (n_gen - rand_start < 700) begin
            s = 16'($urandom_range(0, 10));
            set_timing(s, ($urandom_range(4) == 0) ? 16'($urandom_range(0, s)) :
                       16'(s + $urandom_range(0, 25)),
                       16'($urandom_range(1, 20)), 8'($urandom_range(0, 8)));
            repeat (8) add_gesture();
        end

        // extreme settings
        set_timing(16'd0, 16'd0, 16'd1, 8'd0);
        repeat (12) add_gesture();

        // longest window and longest confirm delay
        set_timing(16'd0, 16'hFFFF, 16'hFFFF, 8'hFF);
        add_item(CMD_EDGE, 1'b0);
        add_ticks(5, 1'b0);
        add_item(CMD_EDGE, 1'b1);
        add_item(CMD_EDGE, 1'b0);
        add_ticks(255, 1'b0);
        add_item(CMD_EDGE, 1'b1);

        settle();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d items under %0d timing settings (plus reset values)", n_in, n_settings);
        $display("Checked gestures: %0d short, %0d long, %0d double click",
                 n_kind[0], n_kind[1], n_kind[2]);
        if (n_err == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- button_gesture_classifier.f -----
design/bgc_pkg.sv
design/bgc_core.sv
design/button_gesture_classifier.sv
design/bgc_checker.sv
verif/tb_button_gesture_classifier.sv
